/* design/hdu_pkg.sv */
package hdu_pkg;

	localparam int COORD_FRAC_BITS_DEF = 23;

	localparam int ROT_STEPS  = 30;
	localparam int SQRT_STEPS = 32;

	localparam logic [21:0]        RADIUS_RESET = 22'd1013504;
	localparam logic signed [33:0] KINV_Q30     = 34'sd652032874;
	localparam logic [31:0]        PI_Q30       = 32'd3373259426;
	localparam logic [60:0]        ONE_Q60      = 61'd1 << 60;

	// pi/180 in Q38, split in two halves for the degree to radian product
	localparam logic [16:0] RAD_C_HI = 17'd73204;
	localparam logic [15:0] RAD_C_LO = 16'd27173;

	// floor(2^22/45) and floor(2^24/5)
	localparam logic [16:0] RECIP_45 = 17'd93206;
	localparam logic [21:0] RECIP_5  = 22'd3355443;

	typedef struct packed {
		logic [17:0] q;
		logic [2:0]  r;
	} div5_t;

	// atan(2^-i) in Q30
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'd843314857;
			1: v = 32'd497837829;
			2: v = 32'd263043837;
			3: v = 32'd133525159;
			4: v = 32'd67021687;
			5: v = 32'd33543516;
			6: v = 32'd16775851;
			7: v = 32'd8388437;
			8: v = 32'd4194283;
			9: v = 32'd2097149;
			default: v = 32'd1 << (30 - i);
		endcase
		return v;
	endfunction

	// quotient and remainder by five, reciprocal multiply and one correction
	function automatic div5_t div5(input logic [20:0] x);
		logic [42:0] prod;
		logic [17:0] q;
		logic [20:0] r;
		div5_t res;
		prod = 43'(x) * 43'(RECIP_5);
		q = 18'(prod >> 24);
		r = x - 21'(21'(q) * 21'd5);
		if (r >= 21'd5) begin
			q = q + 18'd1;
			r = r - 21'd5;
		end
		res.q = q;
		res.r = 3'(r);
		return res;
	endfunction

endpackage

/* design/haversine_distance_unit.sv */
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------
// input     | in_valid / in_ready   | first/second latitude and longitude
// output    | out_valid / out_ready | central_angle, distance_miles, distance_km
// config    | cfg_wr_en             | cfg_wr_data (sphere radius)
//
// one beat enters per cycle while the pipeline is not held; the depth is set by the two 30-step
// cordic pipelines and the 32-step root pipeline, one step per stage
// the whole pipeline advances together: it holds only while the last stage
// has a beat that is not taken; bubbles inside move along and are not squeezed out
// reset clears the valid bits and loads the radius with 3959 miles
module haversine_distance_unit import hdu_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        central_angle,
	output logic [31:0]        distance_miles,
	output logic [32:0]        distance_km,
	input  logic               cfg_wr_en,
	input  logic [21:0]        cfg_wr_data
);

	localparam int F = COORD_FRAC_BITS;
	localparam logic [63:0] P_DEG    = 64'd360 << F;
	localparam logic [63:0] HALF_P   = 64'd180 << F;
	localparam logic [63:0] Q90      = 64'd90 << F;
	localparam logic [63:0] N_WRAP   = ((64'd1 << 32) + P_DEG - 64'd1) / P_DEG;
	localparam logic [63:0] WRAP_OFS = HALF_P + N_WRAP * P_DEG;
	localparam int          HSH      = F + 3;
	localparam logic [35:0] LOW_MASK = (36'd1 << HSH) - 36'd1;
	localparam int          SH_SIN   = F + 9;
	localparam int          SH_COS   = F + 8;
	localparam logic signed [33:0] Q90_S  = 34'(Q90);
	localparam logic signed [33:0] Q180_S = 34'(HALF_P);
	localparam logic signed [64:0] ONE_S  = 65'(ONE_Q60);
	localparam int LAT = 107;

	logic           en;
	logic [LAT:1]   vld_s;
	logic [21:0]    radius_q;

	assign en        = !vld_s[LAT] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// lanes: 0 latitude difference, 1 longitude difference, 2 and 3 latitudes
	logic signed [33:0] wx_s1 [0:3];
	logic [35:0]        wv_s2 [0:3];
	logic [35:0]        wv_s3 [0:3];
	logic [11:0]        wq_s3 [0:3];
	logic signed [33:0] wr_n  [0:3];
	logic signed [33:0] wr_s4 [0:3];
	logic [31:0]        fm_n  [0:3];
	logic [3:0]         fsg_n;
	logic [1:0]         fneg_n;
	logic [31:0]        fm_s5 [0:3];
	logic [3:0]         sg_s5;
	logic [1:0]         neg_s5;
	logic [48:0]        ph_s6 [0:3];
	logic [47:0]        pl_s6 [0:3];
	logic [3:0]         sg_s6;
	logic [1:0]         neg_s6;
	logic signed [33:0] z_n   [0:3];
	logic signed [33:0] z_s7  [0:3];
	logic [1:0]         neg_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1[0] <= 34'(second_latitude) - 34'(first_latitude);
			wx_s1[1] <= 34'(second_longitude) - 34'(first_longitude);
			wx_s1[2] <= 34'(first_latitude);
			wx_s1[3] <= 34'(second_latitude);
			for (int k = 0; k < 4; k++) begin
				// offset keeps the value positive and centers the wrap
				wv_s2[k] <= 36'(wx_s1[k]) + WRAP_OFS[35:0];
				wv_s3[k] <= wv_s2[k];
				wq_s3[k] <= 12'((34'(17'(wv_s2[k] >> HSH)) * 34'(RECIP_45)) >> 22);
				wr_s4[k] <= wr_n[k];
				fm_s5[k] <= fm_n[k];
				ph_s6[k] <= 49'(fm_s5[k]) * 49'(RAD_C_HI);
				pl_s6[k] <= 48'(fm_s5[k]) * 48'(RAD_C_LO);
				z_s7[k]  <= z_n[k];
			end
			sg_s5  <= fsg_n;
			neg_s5 <= fneg_n;
			sg_s6  <= sg_s5;
			neg_s6 <= neg_s5;
			neg_s7 <= neg_s6;
		end
	end

	// modulo 360 degrees: 360 deg = 45 * 2^(F+3), so only the top part is reduced
	always_comb begin
		logic [16:0] hq;
		logic [17:0] rm;
		logic [35:0] md;
		logic [35:0] df;
		for (int k = 0; k < 4; k++) begin
			hq = 17'(wv_s3[k] >> HSH);
			rm = 18'(hq) - 18'(18'(wq_s3[k]) * 18'd45);
			if (rm >= 18'd45) begin
				rm = rm - 18'd45;
			end
			md = (36'(rm) << HSH) | (wv_s3[k] & LOW_MASK);
			df = md - HALF_P[35:0];
			wr_n[k] = signed'(df[33:0]);
		end
	end

	// latitudes past the pole fold back with a negated cosine
	always_comb begin
		logic signed [33:0] r;
		for (int k = 0; k < 4; k++) begin
			r = wr_s4[k];
			if (k >= 2) begin
				fneg_n[k-2] = 1'b0;
				if (r > Q90_S) begin
					r = Q180_S - r;
					fneg_n[k-2] = 1'b1;
				end else if (r < -Q90_S) begin
					r = -Q180_S - r;
					fneg_n[k-2] = 1'b1;
				end
			end
			fsg_n[k] = r[33];
			fm_n[k]  = r[33] ? 32'(-r) : 32'(r);
		end
	end

	// radians in Q30, rounded on the magnitude; difference lanes are halved
	always_comb begin
		logic [64:0]        sm;
		logic [30:0]        mg;
		logic signed [33:0] zz;
		for (int k = 0; k < 4; k++) begin
			if (k < 2) begin
				sm = (65'(ph_s6[k]) << 16) + 65'(pl_s6[k]) + (65'd1 << (SH_SIN - 1));
				mg = 31'(sm >> SH_SIN);
			end else begin
				sm = (65'(ph_s6[k]) << 16) + 65'(pl_s6[k]) + (65'd1 << (SH_COS - 1));
				mg = 31'(sm >> SH_COS);
			end
			zz = 34'(mg);
			z_n[k] = sg_s6[k] ? -zz : zz;
		end
	end

	// rotation cordic, index i of the arrays is stage 7 + i
	logic signed [33:0] rot_x_s [1:ROT_STEPS][0:3];
	logic signed [33:0] rot_y_s [1:ROT_STEPS][0:3];
	logic signed [33:0] rot_z_s [1:ROT_STEPS][0:3];
	logic [1:0]         rot_neg_s [1:ROT_STEPS];

	for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
		localparam logic signed [33:0] AT = 34'(atan_q30(i));
		logic signed [33:0] sx [0:3];
		logic signed [33:0] sy [0:3];
		logic signed [33:0] sz [0:3];
		logic [1:0]         sn;
		if (i == 0) begin : g_src
			always_comb begin
				for (int k = 0; k < 4; k++) begin
					sx[k] = KINV_Q30;
					sy[k] = '0;
					sz[k] = z_s7[k];
				end
				sn = neg_s7;
			end
		end else begin : g_src
			always_comb begin
				for (int k = 0; k < 4; k++) begin
					sx[k] = rot_x_s[i][k];
					sy[k] = rot_y_s[i][k];
					sz[k] = rot_z_s[i][k];
				end
				sn = rot_neg_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) begin
					if (!sz[k][33]) begin
						rot_x_s[i+1][k] <= sx[k] - (sy[k] >>> i);
						rot_y_s[i+1][k] <= sy[k] + (sx[k] >>> i);
						rot_z_s[i+1][k] <= sz[k] - AT;
					end else begin
						rot_x_s[i+1][k] <= sx[k] + (sy[k] >>> i);
						rot_y_s[i+1][k] <= sy[k] - (sx[k] >>> i);
						rot_z_s[i+1][k] <= sz[k] + AT;
					end
				end
				rot_neg_s[i+1] <= sn;
			end
		end
	end

	// haversine term a = s1^2 + c1*c2*s2^2 in Q60
	logic signed [31:0] sw1, sw2, c1w, c2w;
	logic signed [63:0] cc_full, tp_full, p2_full, s1sq_full;
	logic signed [31:0] cc_s38, s2_s38, tmp_s39, s2_s39;
	logic signed [63:0] s1sq_s38, s1sq_s39, s1sq_s40, p2_s40;
	logic signed [64:0] asum;
	logic [60:0]        a_cl;
	logic [63:0]        va_s41 [0:1];

	assign sw1 = 32'(rot_y_s[ROT_STEPS][0]);
	assign sw2 = 32'(rot_y_s[ROT_STEPS][1]);
	assign c1w = rot_neg_s[ROT_STEPS][0] ? 32'(-rot_x_s[ROT_STEPS][2])
		: 32'(rot_x_s[ROT_STEPS][2]);
	assign c2w = rot_neg_s[ROT_STEPS][1] ? 32'(-rot_x_s[ROT_STEPS][3])
		: 32'(rot_x_s[ROT_STEPS][3]);
	assign cc_full   = c1w * c2w;
	assign s1sq_full = sw1 * sw1;
	assign tp_full   = cc_s38 * s2_s38;
	assign p2_full   = tmp_s39 * s2_s39;
	assign asum      = 65'(s1sq_s40) + 65'(p2_s40);

	always_comb begin
		priority if (asum[64]) begin
			a_cl = '0;
		end else if (asum > ONE_S) begin
			a_cl = ONE_Q60;
		end else begin
			a_cl = 61'(asum);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s38    <= 32'(cc_full >>> 30);
			s1sq_s38  <= s1sq_full;
			s2_s38    <= sw2;
			tmp_s39   <= 32'(tp_full >>> 30);
			s2_s39    <= s2_s38;
			s1sq_s39  <= s1sq_s38;
			p2_s40    <= p2_full;
			s1sq_s40  <= s1sq_s39;
			va_s41[0] <= 64'(ONE_Q60 - a_cl);
			va_s41[1] <= 64'(a_cl);
		end
	end

	// digit-by-digit roots, index i is stage 41 + i; lane 0 sqrt(1-a), lane 1 sqrt(a)
	logic [63:0] sq_v_s [1:SQRT_STEPS][0:1];
	logic [63:0] sq_r_s [1:SQRT_STEPS][0:1];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] sv [0:1];
		logic [63:0] sr [0:1];
		logic [63:0] tr [0:1];
		if (i == 0) begin : g_src
			always_comb begin
				for (int k = 0; k < 2; k++) begin
					sv[k] = va_s41[k];
					sr[k] = '0;
				end
			end
		end else begin : g_src
			always_comb begin
				for (int k = 0; k < 2; k++) begin
					sv[k] = sq_v_s[i][k];
					sr[k] = sq_r_s[i][k];
				end
			end
		end
		always_comb begin
			for (int k = 0; k < 2; k++) begin
				tr[k] = sr[k] + BIT;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 2; k++) begin
					if (sv[k] >= tr[k]) begin
						sq_v_s[i+1][k] <= sv[k] - tr[k];
						sq_r_s[i+1][k] <= (sr[k] >> 1) + BIT;
					end else begin
						sq_v_s[i+1][k] <= sv[k];
						sq_r_s[i+1][k] <= sr[k] >> 1;
					end
				end
			end
		end
	end

	// vectoring cordic for atan2, index i is stage 73 + i
	logic signed [33:0] vec_x_s [1:ROT_STEPS];
	logic signed [33:0] vec_y_s [1:ROT_STEPS];
	logic signed [33:0] vec_z_s [1:ROT_STEPS];

	for (genvar i = 0; i < ROT_STEPS; i++) begin : g_vec
		localparam logic signed [33:0] AT = 34'(atan_q30(i));
		logic signed [33:0] sx, sy, sz;
		if (i == 0) begin : g_src
			assign sx = 34'(sq_r_s[SQRT_STEPS][0]);
			assign sy = 34'(sq_r_s[SQRT_STEPS][1]);
			assign sz = '0;
		end else begin : g_src
			assign sx = vec_x_s[i];
			assign sy = vec_y_s[i];
			assign sz = vec_z_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!sy[33]) begin
					vec_x_s[i+1] <= sx + (sy >>> i);
					vec_y_s[i+1] <= sy - (sx >>> i);
					vec_z_s[i+1] <= sz + AT;
				end else begin
					vec_x_s[i+1] <= sx - (sy >>> i);
					vec_y_s[i+1] <= sy + (sx >>> i);
					vec_z_s[i+1] <= sz - AT;
				end
			end
		end
	end

	// angle clamp, radius product, rounding and the km conversion
	logic signed [34:0] z2;
	logic [31:0]        ang_n;
	logic [31:0]        ang_s104, ang_s105, ang_s106, ang_s107;
	logic [53:0]        pr_s105;
	logic [57:0]        nn;
	div5_t              d1, d2;
	logic [31:0]        mi_s106, mi_s107;
	logic [17:0]        q1_s106, hl_s106;
	logic [2:0]         r1_s106;
	logic [32:0]        km_s107;

	assign z2 = {vec_z_s[ROT_STEPS], 1'b0};

	always_comb begin
		priority if (z2[34]) begin
			ang_n = '0;
		end else if (z2 > 35'(PI_Q30)) begin
			ang_n = PI_Q30;
		end else begin
			ang_n = 32'(z2);
		end
	end

	// km = floor(floor((8p + 5*2^21) / 2^22) / 5), split into two narrow divides
	assign nn = (58'(pr_s105) << 3) + 58'd10485760;
	assign d1 = div5(21'(nn >> 40));
	assign d2 = div5({r1_s106, hl_s106});

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s104 <= ang_n;
			pr_s105  <= 54'(radius_q) * 54'(ang_s104);
			ang_s105 <= ang_s104;
			mi_s106  <= 32'((pr_s105 + 54'd2097152) >> 22);
			q1_s106  <= d1.q;
			r1_s106  <= d1.r;
			hl_s106  <= 18'(nn >> 22);
			ang_s106 <= ang_s105;
			mi_s107  <= mi_s106;
			km_s107  <= (33'(q1_s106) << 18) + 33'(d2.q);
			ang_s107 <= ang_s106;
		end
	end

	assign central_angle  = ang_s107;
	assign distance_miles = mi_s107;
	assign distance_km    = km_s107;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> central_angle <= PI_Q30)
		else $error("central angle above pi");

	a_km_not_below_miles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 33'(distance_miles) <= distance_km)
		else $error("km figure below miles figure");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_beat_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[1])
		else $error("accepted beat lost at pipeline entry");

endmodule
